// File: rtl/brb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer with line detection.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH_DEFAULT    = 256;
  localparam int MAX_TERM_DEFAULT = 4;

  // terminator register holds four bytes; bytes beyond read as zero
  localparam int TERM_REG_BYTES = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_TERM_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TERM_LENGTH = 2'd1;

  localparam logic [31:0] TERM_BYTES_RESET  = 32'h0000_0A0D;
  localparam logic [2:0]  TERM_LENGTH_RESET = 3'd2;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_GET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] write_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic       dropped_oldest;
    logic [7:0] fill_level;
    logic [7:0] line_length;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_init;
    logic scan_run;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/brb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: accept, execute action, scan for a line, hand off the result.
// ----------------------------------------------------------------------------
module brb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire brb_pkg::dp_status_t    status,
  output      brb_pkg::ctrl_cmd_t     cmd
);

  brb_pkg::state_t state;
  brb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      brb_pkg::ST_IDLE: begin
        if (in_valid) state_next = brb_pkg::ST_EXEC;
      end
      brb_pkg::ST_EXEC: begin
        state_next = brb_pkg::ST_SCAN_INIT;
      end
      brb_pkg::ST_SCAN_INIT: begin
        state_next = brb_pkg::ST_SCAN;
      end
      brb_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = brb_pkg::ST_FINISH;
      end
      brb_pkg::ST_FINISH: begin
        if (status.out_free) state_next = brb_pkg::ST_IDLE;
      end
      default: begin
        state_next = brb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd           = '0;
    case (state)
      brb_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      brb_pkg::ST_EXEC:      cmd.exec      = 1'b1;
      brb_pkg::ST_SCAN_INIT: cmd.scan_init = 1'b1;
      brb_pkg::ST_SCAN:      cmd.scan_run  = 1'b1;
      brb_pkg::ST_FINISH:    cmd.load_out  = status.out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/brb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_dp
// Datapath: byte store, pointers, terminator registers, line scanner and
// result register.
// ----------------------------------------------------------------------------
module brb_dp #(
  parameter int DEPTH          = brb_pkg::DEPTH_DEFAULT,
  parameter int MAX_TERMINATOR = brb_pkg::MAX_TERM_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [brb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [brb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire brb_pkg::in_t                       in_data,
  input  wire brb_pkg::ctrl_cmd_t                 cmd,
  output      brb_pkg::dp_status_t                status,
  input  wire logic                               out_stall,
  output      logic                               out_valid,
  output      brb_pkg::out_t                      out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int SW    = (PTR_W + 1 > 8) ? PTR_W + 1 : 8;
  localparam int MW    = $clog2(MAX_TERMINATOR + 1);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic [31:0]       term_bytes;
  logic [2:0]        term_length;
  brb_pkg::in_t      item;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data;
  logic              get_ok;
  logic              dropped;
  logic [7:0]        rbyte;
  logic [PTR_W-1:0]  scan_idx;
  logic              cmp_pend;
  logic              found;
  logic [MW-1:0]     matched;
  logic [PTR_W-1:0]  size;
  logic [7:0]        line_len;

  logic [PTR_W-1:0]  wp_adv;
  logic [PTR_W-1:0]  rp_adv;
  logic              is_full;
  logic              is_empty;
  logic [MW-1:0]     need;
  logic [7:0]        tb;
  logic [MW-1:0]     matched_inc;
  logic              hit;
  logic              issue;
  logic              compare;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [SW-1:0]     fill;
  logic [SW-1:0]     len_sum;

  assign wp_adv   = next_slot(wp);
  assign rp_adv   = next_slot(rp);
  assign is_full  = (wp_adv == rp);
  assign is_empty = (rp == wp);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      term_bytes  <= brb_pkg::TERM_BYTES_RESET;
      term_length <= brb_pkg::TERM_LENGTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == brb_pkg::REG_TERM_BYTES) begin
        term_bytes <= cfg_data[31:0];
      end else if (cfg_index == brb_pkg::REG_TERM_LENGTH) begin
        term_length <= cfg_data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item <= in_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
    end else if (cmd.exec) begin
      case (item.action)
        brb_pkg::ACT_PUT: begin
          if (is_full) rp <= rp_adv;
          wp <= wp_adv;
        end
        brb_pkg::ACT_GET: begin
          if (!is_empty) rp <= rp_adv;
        end
        brb_pkg::ACT_CLEAR: begin
          rp <= '0;
          wp <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      dropped <= (item.action == brb_pkg::ACT_PUT) && is_full;
      get_ok  <= (item.action == brb_pkg::ACT_GET) && !is_empty;
    end
  end

  // byte store, single port
  assign rd_en   = (cmd.exec && item.action == brb_pkg::ACT_GET) || issue;
  assign rd_addr = cmd.exec ? rp : scan_idx;

  always_ff @(posedge clk) begin
    if (cmd.exec && item.action == brb_pkg::ACT_PUT) begin
      mem[wp] <= item.write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // terminator match
  always_comb begin
    if ({1'b0, term_length} > 4'(MAX_TERMINATOR)) begin
      need = MW'(MAX_TERMINATOR);
    end else begin
      need = MW'(term_length);
    end
  end

  always_comb begin
    tb = 8'd0;
    for (int k = 0; k < brb_pkg::TERM_REG_BYTES; k++) begin
      if (k < MAX_TERMINATOR && matched == MW'(k)) tb = term_bytes[8*k +: 8];
    end
  end

  assign matched_inc = matched + MW'(1);
  assign hit         = (rd_data == tb);
  assign issue       = cmd.scan_run && !found && (need != '0) && (scan_idx != wp);
  assign compare     = cmd.scan_run && cmp_pend && !found;
  assign len_sum     = SW'(size) + SW'(1);

  assign status.scan_done = found || (need == '0) || ((scan_idx == wp) && !cmp_pend);

  // scan: each address is issued, and its byte is compared in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.scan_init) begin
      cmp_pend <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_pend <= issue;
      if (compare && hit && matched_inc >= need) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      rbyte    <= get_ok ? rd_data : 8'd0;
      scan_idx <= rp;
      matched  <= '0;
      size     <= '0;
      line_len <= 8'd0;
    end else if (cmd.scan_run) begin
      if (issue) scan_idx <= next_slot(scan_idx);
      if (compare) begin
        size <= size + PTR_W'(1);
        if (hit) begin
          matched <= matched_inc;
          if (matched_inc >= need) line_len <= len_sum[7:0];
        end else begin
          // naive matcher: no recheck of this byte
          matched <= '0;
        end
      end
    end
  end

  // fill level after the action
  always_comb begin
    fill = SW'(wp) - SW'(rp);
    if (wp < rp) fill = fill + SW'(DEPTH);
  end

  // result register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.read_byte      <= rbyte;
      out_data.read_valid     <= get_ok;
      out_data.dropped_oldest <= dropped;
      out_data.fill_level     <= fill[7:0];
      out_data.line_length    <= line_len;
    end
  end

endmodule
`default_nettype wire

// File: rtl/byte_ring_buffer_line_detect_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_line_detect_unit
// Byte ring buffer (DEPTH-1 usable) with put/get/clear/query requests and
// first-line length detection on every result.
// ----------------------------------------------------------------------------
// One request is in work at a time. The time from acceptance to the next
// acceptance grows with the fill level and is shorter when a line is found
// early or the terminator length is zero; it is set by the line scan, which
// reads the single-port byte store one byte per cycle from the oldest byte
// onward. The result register lets a new request be accepted while the
// previous result waits to be taken. Configuration is written through
// cfg_we/cfg_index/cfg_data: index 0 is the terminator bytes (first byte in
// bits 7:0), index 1 the terminator length; other indexes are ignored. The
// store needs no clearing after reset.
module byte_ring_buffer_line_detect_unit #(
  parameter int DEPTH          = brb_pkg::DEPTH_DEFAULT,
  parameter int MAX_TERMINATOR = brb_pkg::MAX_TERM_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [brb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [brb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire brb_pkg::in_t                       in_data,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      brb_pkg::out_t                      out_data
);

  brb_pkg::ctrl_cmd_t  cmd;
  brb_pkg::dp_status_t status;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  brb_dp #(
    .DEPTH          (DEPTH),
    .MAX_TERMINATOR (MAX_TERMINATOR)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/brb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks for the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module brb_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire brb_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire brb_pkg::out_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // stalled request stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in work");

  // a result only appears as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result loaded while still busy");

  // taken while idle, nothing new can be ready next cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !in_stall |=> !out_valid)
    else $error("result appeared without a request");

endmodule

bind byte_ring_buffer_line_detect_unit brb_checker u_brb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
